@@ design/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master register controller.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // bus action codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_RECV  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_STATUS   = 3'd1;
  localparam logic [2:0] REG_OWN_ADDR = 3'd2;
  localparam logic [2:0] REG_DATA     = 3'd3;
  localparam logic [2:0] REG_LINE_CTL = 3'd4;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [7:0] CTRL_WR_MASK   = 8'hef;
  localparam logic [7:0] STAT_KEEP_MASK = 8'h0f;
  localparam logic [7:0] STAT_WR_MASK   = 8'hf0;
  localparam logic [7:0] STAT_RUN_MASK  = 8'h90;
  localparam logic [7:0] STAT_RD_MASK   = 8'hdf;
  localparam logic [6:0] OWN_ADDR_MASK  = 7'h7f;

  typedef struct packed {
    logic       kind;
    logic [2:0] reg_index;
    logic [7:0] write_value;
    logic       slave_ack;
    logic [7:0] slave_rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic [2:0] bus_op;
    logic [6:0] bus_address;
    logic       bus_direction_read;
    logic [7:0] bus_tx_byte;
    logic       bus_nack_sent;
  } result_t;

  typedef struct packed {
    logic [7:0] control;
    logic [7:0] status;
    logic [7:0] data;
    logic [6:0] own_address;
    logic [7:0] line_control;
    logic       busy;
    logic       start_pending;
  } regs_t;

endpackage

`default_nettype wire

@@ design/i2cm_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels for register accesses and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] reg_index;
  logic [7:0] write_value;
  logic       slave_ack;
  logic [7:0] slave_rx_byte;

  modport source (
    output valid, kind, reg_index, write_value, slave_ack, slave_rx_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_index, write_value, slave_ack, slave_rx_byte,
    output ready
  );
endinterface

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_pulse;
  logic [2:0] bus_op;
  logic [6:0] bus_address;
  logic       bus_direction_read;
  logic [7:0] bus_tx_byte;
  logic       bus_nack_sent;

  modport source (
    output valid, read_data, irq_pulse, bus_op, bus_address,
           bus_direction_read, bus_tx_byte, bus_nack_sent,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_pulse, bus_op, bus_address,
           bus_direction_read, bus_tx_byte, bus_nack_sent,
    output ready
  );
endinterface

`default_nettype wire

@@ design/i2cm_step.sv @@
// ----------------------------------------------------------------------------
// i2cm_step
// Register access decode and one master bus step, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_step (
  input  var i2cm_pkg::regs_t   regs_i,
  input  var i2cm_pkg::item_t   item_i,
  output i2cm_pkg::regs_t       regs_o,
  output i2cm_pkg::result_t     res_o
);

  i2cm_pkg::regs_t w;       // registers after the plain write
  logic            do_step;
  logic            run;
  logic            ending;
  logic            begin_xfer;
  logic            busy_now;
  logic            ack;

  always_comb begin
    w          = regs_i;
    res_o      = '0;
    do_step    = 1'b0;

    if (item_i.kind == i2cm_pkg::KIND_READ) begin
      unique case (item_i.reg_index)
        i2cm_pkg::REG_CONTROL:  res_o.read_data = regs_i.control;
        i2cm_pkg::REG_STATUS:   res_o.read_data = regs_i.status & i2cm_pkg::STAT_RD_MASK;
        i2cm_pkg::REG_OWN_ADDR: res_o.read_data = {1'b0, regs_i.own_address};
        i2cm_pkg::REG_DATA:     res_o.read_data = regs_i.data;
        i2cm_pkg::REG_LINE_CTL: res_o.read_data = regs_i.line_control;
        default:                res_o.read_data = '0;
      endcase
    end else begin
      unique case (item_i.reg_index)
        i2cm_pkg::REG_CONTROL: begin
          // interrupt pending can only be cleared from software
          w.control = (regs_i.control | i2cm_pkg::CTRL_WR_MASK) & item_i.write_value;
          do_step   = regs_i.busy;
        end
        i2cm_pkg::REG_STATUS: begin
          w.status = (regs_i.status & i2cm_pkg::STAT_KEEP_MASK)
                   | (item_i.write_value & i2cm_pkg::STAT_WR_MASK);
          if (w.status[5]) begin
            w.start_pending = 1'b1;
          end
          do_step = 1'b1;
        end
        i2cm_pkg::REG_OWN_ADDR: w.own_address = item_i.write_value[6:0] & i2cm_pkg::OWN_ADDR_MASK;
        i2cm_pkg::REG_DATA:     w.data = item_i.write_value;
        i2cm_pkg::REG_LINE_CTL: w.line_control = item_i.write_value;
        default: ;
      endcase
    end

    run        = do_step && !w.control[4]
               && ((w.status & i2cm_pkg::STAT_RUN_MASK) == i2cm_pkg::STAT_RUN_MASK);
    ending     = !w.status[5];
    begin_xfer = w.start_pending && !ending;
    busy_now   = w.busy || begin_xfer;
    ack        = 1'b1;
    regs_o     = w;

    if (run) begin
      regs_o.start_pending = 1'b0;
      regs_o.busy          = busy_now;
      if (busy_now) begin
        priority if (begin_xfer) begin
          res_o.bus_op             = i2cm_pkg::OP_START;
          res_o.bus_address        = w.data[7:1];
          res_o.bus_direction_read = !w.status[6];
          ack                      = item_i.slave_ack;
        end else if (ending) begin
          res_o.bus_op = i2cm_pkg::OP_STOP;
        end else if (w.status[6]) begin
          res_o.bus_op      = i2cm_pkg::OP_SEND;
          res_o.bus_tx_byte = w.data;
          ack               = item_i.slave_ack;
        end else begin
          res_o.bus_op        = i2cm_pkg::OP_RECV;
          regs_o.data         = item_i.slave_rx_byte;
          res_o.bus_nack_sent = !w.control[7];
        end

        if (ending) begin
          regs_o.busy = 1'b0;
        end else begin
          regs_o.status[0]  = !ack;
          regs_o.control[4] = 1'b1;
          res_o.irq_pulse   = w.control[5];
          if (!ack) begin
            regs_o.busy = 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/i2c_master_register_controller.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_controller
// Register file and master step sequencing for an I2C bus master.
// ----------------------------------------------------------------------------
// Timing: an accepted request is captured in the input register and its
//   result in the result register; the step logic sits between them.
// Throughput: one access per cycle unless the result side stalls, limited
//   by the register file update loop.
// Reset: all registers, busy and pending start clear to zero; both pipeline
//   stages empty.
`default_nettype none

module i2c_master_register_controller (
  input  wire          clk_i,
  input  wire          rst_ni,
  i2cm_req_if.sink     req_i,
  i2cm_rsp_if.source   rsp_o
);

  logic                in_valid_q;
  i2cm_pkg::item_t     in_q;
  logic                out_valid_q;
  i2cm_pkg::result_t   res_q;
  i2cm_pkg::regs_t     regs_q;
  i2cm_pkg::regs_t     regs_d;
  i2cm_pkg::result_t   res_d;
  logic                advance;

  // the input stage moves on whenever the result stage is free or draining
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  i2cm_step u_step (
    .regs_i (regs_q),
    .item_i (in_q),
    .regs_o (regs_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        regs_q      <= regs_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.kind          <= req_i.kind;
      in_q.reg_index     <= req_i.reg_index;
      in_q.write_value   <= req_i.write_value;
      in_q.slave_ack     <= req_i.slave_ack;
      in_q.slave_rx_byte <= req_i.slave_rx_byte;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.read_data          = res_q.read_data;
  assign rsp_o.irq_pulse          = res_q.irq_pulse;
  assign rsp_o.bus_op             = res_q.bus_op;
  assign rsp_o.bus_address        = res_q.bus_address;
  assign rsp_o.bus_direction_read = res_q.bus_direction_read;
  assign rsp_o.bus_tx_byte        = res_q.bus_tx_byte;
  assign rsp_o.bus_nack_sent      = res_q.bus_nack_sent;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the I2C master register controller against a cycle-free model of
// its register file and master step logic, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 10;

  // control and status bit positions
  localparam int CTL_PEND   = 4;
  localparam int CTL_IRQ_EN = 5;
  localparam int CTL_ACK_EN = 7;
  localparam int ST_NACK    = 0;
  localparam int ST_RUN     = 4;
  localparam int ST_START   = 5;
  localparam int ST_TX      = 6;
  localparam int ST_ENABLE  = 7;

  logic clk_i;
  logic rst_ni;

  i2cm_req_if req_if ();
  i2cm_rsp_if rsp_if ();

  i2c_master_register_controller u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // model copy of the block state
  logic [7:0] mdl_control;
  logic [7:0] mdl_status;
  logic [7:0] mdl_data;
  logic [6:0] mdl_own_addr;
  logic [7:0] mdl_line_ctl;
  logic       mdl_busy;
  logic       mdl_start_pend;

  result_t predicted_responses[$];

  int  items_sent;
  int  results_checked;
  int  fail_count;
  int  cycle_count;
  int  op_seen[5];
  bit  quiet_phase;
  bit  hold_request;

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic void run_master_step(input logic ack_in, input logic [7:0] rx,
                                          inout result_t r);
    logic starting;
    logic ending;
    logic acked;
    starting = 1'b0;
    acked    = 1'b1;
    if (mdl_control[CTL_PEND]) return;
    if ((mdl_status & STAT_RUN_MASK) != STAT_RUN_MASK) return;
    ending = !mdl_status[ST_START];
    if (mdl_start_pend && !ending) begin
      mdl_busy = 1'b1;
      starting = 1'b1;
    end
    mdl_start_pend = 1'b0;
    if (!mdl_busy) return;

    if (starting) begin
      r.bus_op             = OP_START;
      r.bus_address        = mdl_data[7:1];
      r.bus_direction_read = !mdl_status[ST_TX];
      acked                = ack_in;
    end else if (ending) begin
      r.bus_op = OP_STOP;
    end else if (mdl_status[ST_TX]) begin
      r.bus_op      = OP_SEND;
      r.bus_tx_byte = mdl_data;
      acked         = ack_in;
    end else begin
      r.bus_op        = OP_RECV;
      mdl_data        = rx;
      r.bus_nack_sent = !mdl_control[CTL_ACK_EN];
    end

    // a stop (or any step with start cleared) ends the transfer silently
    if (ending) begin
      mdl_busy = 1'b0;
      return;
    end
    mdl_status[ST_NACK] = !acked;
    if (!acked) mdl_busy = 1'b0;
    mdl_control[CTL_PEND] = 1'b1;
    if (mdl_control[CTL_IRQ_EN]) r.irq_pulse = 1'b1;
  endfunction

  function automatic result_t predict_register_access(item_t it);
    result_t r;
    r = '0;
    if (it.kind == KIND_READ) begin
      case (it.reg_index)
        REG_CONTROL:  r.read_data = mdl_control;
        REG_STATUS:   r.read_data = mdl_status & STAT_RD_MASK;
        REG_OWN_ADDR: r.read_data = {1'b0, mdl_own_addr};
        REG_DATA:     r.read_data = mdl_data;
        REG_LINE_CTL: r.read_data = mdl_line_ctl;
        default:      r.read_data = 8'h00;
      endcase
    end else begin
      case (it.reg_index)
        REG_CONTROL: begin
          mdl_control = (mdl_control | CTRL_WR_MASK) & it.write_value;
          if (mdl_busy) run_master_step(it.slave_ack, it.slave_rx_byte, r);
        end
        REG_STATUS: begin
          mdl_status = (mdl_status & STAT_KEEP_MASK) | (it.write_value & STAT_WR_MASK);
          if (mdl_status[ST_START]) mdl_start_pend = 1'b1;
          run_master_step(it.slave_ack, it.slave_rx_byte, r);
        end
        REG_OWN_ADDR: mdl_own_addr = it.write_value[6:0] & OWN_ADDR_MASK;
        REG_DATA:     mdl_data = it.write_value;
        REG_LINE_CTL: mdl_line_ctl = it.write_value;
        default: ;
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_responses.size());
      $display("i2c_master_register_controller: mismatch");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // result side: ready pattern and checker
  // --------------------------------------------------------------------------
  initial begin : ready_driver
    int on_len;
    int off_len;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
        repeat (on_len) @(posedge clk_i);
        off_len = pick_gap();
        if (off_len > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (off_len) @(posedge clk_i);
        end
      end
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic string fmt_result(result_t r);
    return $sformatf("rd=%h irq=%b op=%0d addr=%h dir=%b tx=%h nack=%b", r.read_data,
                     r.irq_pulse, r.bus_op, r.bus_address, r.bus_direction_read,
                     r.bus_tx_byte, r.bus_nack_sent);
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.read_data          = rsp_if.read_data;
      got.irq_pulse          = rsp_if.irq_pulse;
      got.bus_op             = rsp_if.bus_op;
      got.bus_address        = rsp_if.bus_address;
      got.bus_direction_read = rsp_if.bus_direction_read;
      got.bus_tx_byte        = rsp_if.bus_tx_byte;
      got.bus_nack_sent      = rsp_if.bus_nack_sent;
      if (predicted_responses.size() == 0) begin
        note_failure({"result with nothing expected: ", fmt_result(got)});
      end else begin
        want = predicted_responses.pop_front();
        results_checked++;
        if (want.bus_op <= OP_RECV) op_seen[want.bus_op]++;
        if (got !== want)
          note_failure($sformatf("result %0d: expected %s, got %s", results_checked,
                                 fmt_result(want), fmt_result(got)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  task automatic send_access(input logic kind, input logic [2:0] idx, input logic [7:0] val,
                             input logic ack, input logic [7:0] rx);
    item_t it;
    int    gap;
    it = '{kind: kind, reg_index: idx, write_value: val, slave_ack: ack, slave_rx_byte: rx};
    req_if.valid         <= 1'b1;
    req_if.kind          <= kind;
    req_if.reg_index     <= idx;
    req_if.write_value   <= val;
    req_if.slave_ack     <= ack;
    req_if.slave_rx_byte <= rx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted_responses.push_back(predict_register_access(it));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // slaves acknowledge most of the time
  function automatic logic rand_ack();
    return ($urandom_range(0, 5) != 0);
  endfunction

  task automatic send_random_read();
    send_access(KIND_READ, 3'($urandom_range(0, 7)), rand_byte(), rand_ack(), rand_byte());
  endtask

  // control write that clears interrupt pending, so a busy master steps
  task automatic send_step_kick();
    logic [7:0] v;
    v = rand_byte();
    v[CTL_PEND] = 1'b0;
    send_access(KIND_WRITE, REG_CONTROL, v, rand_ack(), rand_byte());
  endtask

  // one bus transfer: address, start, some byte steps, stop
  task automatic run_random_transfer();
    logic [7:0] st;
    int         steps;
    send_access(KIND_WRITE, REG_DATA, rand_byte(), rand_ack(), rand_byte());
    send_step_kick();
    st = rand_byte();
    if ($urandom_range(0, 9) != 0) begin
      st[ST_ENABLE] = 1'b1;
      st[ST_RUN]    = 1'b1;
      st[ST_START]  = 1'b1;
    end
    send_access(KIND_WRITE, REG_STATUS, st, rand_ack(), rand_byte());
    steps = $urandom_range(0, 6);
    repeat (steps) begin
      case ($urandom_range(0, 5))
        0: send_access(KIND_WRITE, REG_DATA, rand_byte(), rand_ack(), rand_byte());
        1: send_random_read();
        5: begin
          // repeated start, possibly with a new direction
          st = rand_byte();
          st[ST_ENABLE] = 1'b1;
          st[ST_RUN]    = 1'b1;
          st[ST_START]  = 1'b1;
          send_access(KIND_WRITE, REG_STATUS, st, rand_ack(), rand_byte());
        end
        default: send_step_kick();
      endcase
    end
    if ($urandom_range(0, 7) != 0) begin
      st = rand_byte();
      st[ST_ENABLE] = 1'b1;
      st[ST_RUN]    = 1'b1;
      st[ST_START]  = 1'b0;
      send_access(KIND_WRITE, REG_STATUS, st, rand_ack(), rand_byte());
      send_step_kick();
    end
    if ($urandom_range(0, 1) == 0)
      send_access(KIND_READ, REG_STATUS, rand_byte(), rand_ack(), rand_byte());
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_register_file();
    send_access(KIND_WRITE, REG_OWN_ADDR, 8'hff, 1'b1, 8'h00);
    send_access(KIND_READ,  REG_OWN_ADDR, 8'h00, 1'b0, 8'hff);
    send_access(KIND_WRITE, REG_LINE_CTL, 8'ha5, 1'b0, 8'h00);
    send_access(KIND_READ,  REG_LINE_CTL, 8'h00, 1'b1, 8'h00);
    send_access(KIND_WRITE, 3'd5,         8'hff, 1'b1, 8'hff);
    send_access(KIND_READ,  3'd7,         8'hff, 1'b1, 8'hff);
    // pending bit must not be settable from software
    send_access(KIND_WRITE, REG_CONTROL,  8'hff, 1'b1, 8'h00);
    send_access(KIND_READ,  REG_CONTROL,  8'h00, 1'b0, 8'h00);
    send_access(KIND_READ,  REG_STATUS,   8'h00, 1'b0, 8'h00);
    send_access(KIND_READ,  3'd6,         8'h00, 1'b0, 8'h00);
  endtask

  task automatic test_directed_transfers();
    // master receive: start, NACKed byte, ACKed byte, stop
    send_access(KIND_WRITE, REG_CONTROL, 8'h20, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_DATA,    8'ha5, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_STATUS,  8'hb0, 1'b1, 8'h00);
    send_access(KIND_READ,  REG_CONTROL, 8'h00, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_CONTROL, 8'h20, 1'b1, 8'h3c);
    send_access(KIND_READ,  REG_DATA,    8'h00, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_CONTROL, 8'ha0, 1'b1, 8'hc3);
    send_access(KIND_WRITE, REG_STATUS,  8'h90, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_CONTROL, 8'h00, 1'b1, 8'h00);
    send_access(KIND_READ,  REG_STATUS,  8'h00, 1'b1, 8'h00);
    // master transmit, address not acknowledged
    send_access(KIND_WRITE, REG_DATA,    8'hff, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_STATUS,  8'hf0, 1'b0, 8'h00);
    send_access(KIND_WRITE, REG_CONTROL, 8'h20, 1'b1, 8'h00);
    // idle master: no bus action
    send_access(KIND_WRITE, REG_STATUS,  8'hd0, 1'b1, 8'h00);
    // enable bits clear: start is held pending
    send_access(KIND_WRITE, REG_STATUS,  8'h20, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_STATUS,  8'hf0, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_DATA,    8'h00, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_CONTROL, 8'h20, 1'b1, 8'h00);
    send_access(KIND_WRITE, REG_CONTROL, 8'h20, 1'b0, 8'h00);
    send_access(KIND_READ,  REG_STATUS,  8'h00, 1'b0, 8'h00);
  endtask

  task automatic test_random_transfers(input int n_items);
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < n_items) run_random_transfer();
  endtask

  task automatic test_back_to_back();
    int start_count;
    quiet_phase = 1'b1;
    start_count = items_sent;
    while (items_sent - start_count < 120) run_random_transfer();
    quiet_phase = 1'b0;
  endtask

  task automatic test_result_backpressure();
    int start_count;
    quiet_phase  = 1'b1;
    hold_request = 1'b1;
    start_count  = items_sent;
    while (items_sent - start_count < 40) run_random_transfer();
    quiet_phase = 1'b0;
  endtask

  task automatic test_random_noise(input int n_items);
    repeat (n_items)
      send_access(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), rand_byte(),
                  1'($urandom_range(0, 1)), rand_byte());
  endtask

  initial begin
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.kind           <= KIND_READ;
    req_if.reg_index      <= REG_CONTROL;
    req_if.write_value    <= 8'h00;
    req_if.slave_ack      <= 1'b0;
    req_if.slave_rx_byte  <= 8'h00;
    mdl_control    = '0;
    mdl_status     = '0;
    mdl_data       = '0;
    mdl_own_addr   = '0;
    mdl_line_ctl   = '0;
    mdl_busy       = 1'b0;
    mdl_start_pend = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_file();
    test_directed_transfers();
    test_random_transfers(700);
    test_result_backpressure();
    test_random_noise(250);
    test_back_to_back();
    test_random_transfers(500);
    test_random_noise(150);

    req_if.valid <= 1'b0;
    while (predicted_responses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d accesses sent, %0d results checked, %0d failures", items_sent,
             results_checked, fail_count);
    $display("bus steps: %0d start, %0d stop, %0d send, %0d receive", op_seen[OP_START],
             op_seen[OP_STOP], op_seen[OP_SEND], op_seen[OP_RECV]);
    if (fail_count == 0) begin
      $display("i2c_master_register_controller: match");
    end else begin
      $display("i2c_master_register_controller: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_step.sv
design/i2c_master_register_controller.sv
tb/sv/testbench.sv
